>>> sv/lccc_pkg.sv
// Shared constants and types for the card number classifier core.
// Used by the converter, the digit scanner and the top level; no dependencies.
package lccc_pkg;

  localparam int CARD_W   = 63;            // binary card number width
  localparam int DIGITS   = 19;            // decimal digits of a 63-bit value
  localparam int BCD_W    = 4 * DIGITS;    // packed BCD width
  localparam int BITCNT_W = 6;             // counts CARD_W conversion steps
  localparam int COUNT_W  = 5;             // digit count / digit index width

  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_ONE   = 2'd1;
  localparam logic [1:0] CLASS_TWO   = 2'd2;
  localparam logic [1:0] CLASS_THREE = 2'd3;

  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

  // Digit pass results handed from the scanner to the top level
  typedef struct packed {
    logic               luhn_ok;
    logic [COUNT_W-1:0] count;
    logic [3:0]         top;    // most significant nonzero digit
    logic [3:0]         next;   // digit just below it
  } scan_res_t;

endpackage

>>> sv/lccc_dabble.sv
// Bit-serial binary to BCD converter (shift-and-add-3), one input bit per cycle.
// Depends on lccc_pkg.
module lccc_dabble (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lccc_pkg::CARD_W-1:0] card_value,
  output logic                       done,
  output logic [lccc_pkg::BCD_W-1:0]  bcd
);

  localparam logic [lccc_pkg::BITCNT_W-1:0] LAST_STEP =
    lccc_pkg::BITCNT_W'(lccc_pkg::CARD_W - 1);

  logic [lccc_pkg::CARD_W-1:0]   bin_r;
  logic [lccc_pkg::BCD_W-1:0]    bcd_r, bcd_adj;
  logic [lccc_pkg::BITCNT_W-1:0] step_r;
  logic                          busy_r, done_r;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < lccc_pkg::DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= card_value;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[lccc_pkg::CARD_W-2:0], 1'b0};
      bcd_r <= {bcd_adj[lccc_pkg::BCD_W-2:0], bin_r[lccc_pkg::CARD_W-1]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

>>> sv/lccc_scan.sv
// Digit scanner: walks the BCD word one digit per cycle from the low end,
// building the Luhn sum mod 10, the digit count and the two leading digits.
// Depends on lccc_pkg.
module lccc_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lccc_pkg::BCD_W-1:0]  bcd,
  output logic                       done,
  output lccc_pkg::scan_res_t        res
);

  localparam logic [lccc_pkg::COUNT_W-1:0] LAST_IDX =
    lccc_pkg::COUNT_W'(lccc_pkg::DIGITS);

  logic [lccc_pkg::BCD_W-1:0]   sh_r;
  logic [lccc_pkg::COUNT_W-1:0] idx_r, cnt_r;
  logic [3:0]                   sum_r, top_r, next_r, prev_r;
  logic                         busy_r, done_r;

  logic [3:0] dig, wgt, sum_nxt;
  logic [4:0] dbl, acc;

  always_comb begin
    dig = sh_r[3:0];
    dbl = {dig, 1'b0};
    // even positions are doubled, a doubled value above 9 folds to its digit sum
    if (!idx_r[0]) begin
      wgt = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      wgt = dig;
    end
    acc     = {1'b0, sum_r} + {1'b0, wgt};
    sum_nxt = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && idx_r == LAST_IDX) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= bcd;
      idx_r  <= 5'd1;
      cnt_r  <= '0;
      sum_r  <= '0;
      top_r  <= '0;
      next_r <= '0;
      prev_r <= '0;
    end else if (busy_r) begin
      sh_r   <= {4'd0, sh_r[lccc_pkg::BCD_W-1:4]};
      idx_r  <= idx_r + 1'b1;
      sum_r  <= sum_nxt;
      prev_r <= dig;
      if (dig != 4'd0) begin
        cnt_r  <= idx_r;
        top_r  <= dig;
        next_r <= prev_r;
      end
    end
  end

  assign done         = done_r;
  assign res.luhn_ok  = (sum_r == 4'd0);
  assign res.count    = cnt_r;
  assign res.top      = top_r;
  assign res.next     = next_r;

endmodule

>>> sv/luhn_card_number_classifier_core.sv
// Top level of the card number classifier: sequencer, issuer classing, output register.
// Depends on lccc_pkg, lccc_dabble and lccc_scan.
//
//  channel | direction | ports                                             | handshake
//  in      | input     | in_card_value[62:0]                               | in_valid / in_ready
//  out     | output    | out_issuer_class, out_luhn_ok, out_digit_count    | out_valid / out_ready
//
// An item passes from its transfer to its result through 63 conversion steps (one input
// bit per cycle through the shift-and-add-3 register), 19 digit steps in the scanner
// and the hand-offs between them. One item is in work at a time; in_ready is high
// while the sequencer idles, also while a result waits in the output register.
// A result that cannot enter the output register waits in ST_HOLD, kept in the scanner, until out_ready.
// Reset is synchronous on rst_n and clears the sequencer and out_valid.
module luhn_card_number_classifier_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lccc_pkg::CARD_W-1:0] in_card_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_issuer_class,
  output logic                       out_luhn_ok,
  output logic [lccc_pkg::COUNT_W-1:0] out_digit_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic                        in_xfer, dab_done, scan_done, load_out;
  logic [lccc_pkg::BCD_W-1:0]   bcd;
  lccc_pkg::scan_res_t         res;
  logic [1:0]                  cls;

  logic                        out_valid_r;
  logic [1:0]                  cls_r;
  logic                        ok_r;
  logic [lccc_pkg::COUNT_W-1:0] cnt_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  lccc_dabble u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_xfer),
    .card_value (in_card_value),
    .done       (dab_done),
    .bcd        (bcd)
  );

  lccc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_done),
    .bcd   (bcd),
    .done  (scan_done),
    .res   (res)
  );

  // classes tried in order; any class needs a passing check
  always_comb begin
    cls = lccc_pkg::CLASS_NONE;
    if (res.luhn_ok) begin
      if (res.count == lccc_pkg::LEN_15 && res.top == 4'd3 &&
          (res.next == 4'd4 || res.next == 4'd7)) begin
        cls = lccc_pkg::CLASS_ONE;
      end else if (res.count == lccc_pkg::LEN_16 && res.top == 4'd5 &&
                   res.next >= 4'd1 && res.next <= 4'd5) begin
        cls = lccc_pkg::CLASS_TWO;
      end else if ((res.count == lccc_pkg::LEN_16 || res.count == lccc_pkg::LEN_13) &&
                   res.top == 4'd4) begin
        cls = lccc_pkg::CLASS_THREE;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_CONV;
      ST_CONV: if (dab_done) state_nxt = ST_SCAN;
      ST_SCAN, ST_HOLD: begin
        if (scan_done || state_r == ST_HOLD) begin
          if (!out_valid_r || out_ready) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cls_r <= cls;
      ok_r  <= res.luhn_ok;
      cnt_r <= res.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_issuer_class = cls_r;
  assign out_luhn_ok      = ok_r;
  assign out_digit_count  = cnt_r;

endmodule

>>> sv/lccc_checker.sv
// Port-level checker for the card number classifier core, bound to the top level.
// Depends on lccc_pkg and luhn_card_number_classifier_core.
module lccc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_issuer_class,
  input logic                       out_luhn_ok,
  input logic [lccc_pkg::COUNT_W-1:0] out_digit_count
);

  // one item in work at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_count <= 5'd19)
    else $error("digit count out of range");

  a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issuer_class != lccc_pkg::CLASS_NONE |-> out_luhn_ok)
    else $error("issuer class given on a failed check");

  a_class_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issuer_class == lccc_pkg::CLASS_ONE |-> out_digit_count == 5'd15)
    else $error("class one with wrong length");

endmodule

bind luhn_card_number_classifier_core lccc_checker u_lccc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_issuer_class (out_issuer_class),
  .out_luhn_ok      (out_luhn_ok),
  .out_digit_count  (out_digit_count)
);

>>> test/luhn_card_number_classifier_core_tb.sv
// Self-checking testbench for luhn_card_number_classifier_core: digit count, Luhn flag, class.
// Depends on lccc_pkg and the core RTL; a local predictor checks every result in transfer order.
module luhn_card_number_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 450;
  localparam int STUCK_LIMIT     = 4000;   // cycles without any transfer
  localparam int TAIL_CYCLES     = 200;
  localparam int NUM_PHASES      = 4;

  typedef struct packed {
    logic [1:0]                   issuer_class;
    logic                         luhn_ok;
    logic [lccc_pkg::COUNT_W-1:0] digit_count;
  } card_verdict_t;

  typedef struct packed {
    logic [lccc_pkg::CARD_W-1:0] card;
    card_verdict_t               verdict;
  } pending_verdict_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [lccc_pkg::CARD_W-1:0]  in_card_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_issuer_class;
  logic                         out_luhn_ok;
  logic [lccc_pkg::COUNT_W-1:0] out_digit_count;

  logic [lccc_pkg::CARD_W-1:0]  card_queue[$];
  pending_verdict_t             verdict_queue[$];
  int                           send_idle_pct = 0;
  int                           recv_stall_pct = 0;
  int                           mismatches = 0;
  int                           stuck_cycles = 0;

  luhn_card_number_classifier_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_card_value    (in_card_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_issuer_class (out_issuer_class),
    .out_luhn_ok      (out_luhn_ok),
    .out_digit_count  (out_digit_count)
  );

  always #5 clk = ~clk;

  // Digit walk from the low end; every second digit doubled and folded.
  function automatic card_verdict_t classify_card(input logic [lccc_pkg::CARD_W-1:0] card);
    longint unsigned rest;
    int unsigned     digit;
    int unsigned     ndig;
    int unsigned     weighted_sum;
    int unsigned     msd;
    int unsigned     second;
    int unsigned     lead_pair;
    card_verdict_t   v;
    rest = {1'b0, card};
    ndig = 0;
    weighted_sum = 0;
    msd = 0;
    second = 0;
    while (rest != 0) begin
      digit = 32'(rest % 10);
      rest = rest / 10;
      ndig++;
      if (ndig % 2 == 0) begin
        weighted_sum += (digit * 2 > 9) ? digit * 2 - 9 : digit * 2;
      end else begin
        weighted_sum += digit;
      end
      second = msd;
      msd = digit;
    end
    v.luhn_ok      = (weighted_sum % 10 == 0);
    v.digit_count  = ndig[lccc_pkg::COUNT_W-1:0];
    v.issuer_class = lccc_pkg::CLASS_NONE;
    lead_pair = msd * 10 + second;
    if (v.luhn_ok && ndig >= 2) begin
      if (ndig == lccc_pkg::LEN_15 && (lead_pair == 34 || lead_pair == 37)) begin
        v.issuer_class = lccc_pkg::CLASS_ONE;
      end else if (ndig == lccc_pkg::LEN_16 && lead_pair >= 51 && lead_pair <= 55) begin
        v.issuer_class = lccc_pkg::CLASS_TWO;
      end else if ((ndig == lccc_pkg::LEN_16 || ndig == lccc_pkg::LEN_13) && msd == 4) begin
        v.issuer_class = lccc_pkg::CLASS_THREE;
      end
    end
    return v;
  endfunction

  // Card of ndig digits starting with lead, random body, check digit fixed up for Luhn.
  function automatic logic [lccc_pkg::CARD_W-1:0] make_card(input int unsigned ndig,
                                                           input int unsigned lead);
    longint unsigned             value;
    int unsigned                 have;
    logic [lccc_pkg::CARD_W-1:0] cand;
    card_verdict_t               chk;
    value = 64'(lead);
    have = (lead < 10) ? 1 : 2;
    while (have < ndig - 1) begin
      value = value * 10 + 64'($urandom_range(9));
      have++;
    end
    value = value * 10;
    for (int d = 0; d < 10; d++) begin
      cand = lccc_pkg::CARD_W'(value + 64'(d));
      chk = classify_card(cand);
      if (chk.luhn_ok) return cand;
    end
    return lccc_pkg::CARD_W'(value);
  endfunction

  // Bumping the check digit always breaks the Luhn sum.
  function automatic logic [lccc_pkg::CARD_W-1:0] break_card(
    input logic [lccc_pkg::CARD_W-1:0] card);
    return card - (card % 10) + ((card % 10 + 1) % 10);
  endfunction

  function automatic logic [lccc_pkg::CARD_W-1:0] random_card();
    int unsigned     leads[12] = '{34, 37, 35, 51, 55, 53, 50, 56, 4, 6, 1, 8};
    int unsigned     lens[11]  = '{13, 15, 16, 16, 15, 13, 12, 14, 17, 18, 19};
    int unsigned     sel;
    longint unsigned raw;
    sel = $urandom_range(99);
    raw = {$urandom, $urandom};
    raw = raw & 64'h7FFF_FFFF_FFFF_FFFF;
    if (sel < 60) begin
      return make_card(lens[$urandom_range(10)], leads[$urandom_range(11)]);
    end else if (sel < 72) begin
      return break_card(make_card(lens[$urandom_range(10)], leads[$urandom_range(11)]));
    end else if (sel < 87) begin
      return lccc_pkg::CARD_W'(raw);
    end
    return lccc_pkg::CARD_W'(raw >> $urandom_range(62));
  endfunction

  // Driver: picks up the next card once the current one has transferred.
  always @(posedge clk) begin
    logic [lccc_pkg::CARD_W-1:0] card;
    if (in_valid && in_ready) begin
      verdict_queue.push_back('{card: in_card_value, verdict: classify_card(in_card_value)});
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (card_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        card = card_queue.pop_front();
        in_valid <= 1'b1;
        in_card_value <= card;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure, each result checked against the oldest prediction.
  always @(posedge clk) begin
    pending_verdict_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (out_valid && out_ready) begin
      if (verdict_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: class %0d luhn %0b digits %0d",
                   out_issuer_class, out_luhn_ok, out_digit_count);
      end else begin
        want = verdict_queue.pop_front();
        if (out_issuer_class !== want.verdict.issuer_class ||
            out_luhn_ok !== want.verdict.luhn_ok ||
            out_digit_count !== want.verdict.digit_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("card %0d: expected class %0d luhn %0b digits %0d, got %0d %0b %0d",
                     want.card, want.verdict.issuer_class, want.verdict.luhn_ok,
                     want.verdict.digit_count, out_issuer_class, out_luhn_ok,
                     out_digit_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL luhn_card_number_classifier_core");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int idle_pct[NUM_PHASES]  = '{0, 57, 0, 10};
    int stall_pct[NUM_PHASES] = '{0, 0, 57, 10};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero, single digit, smallest two-digit Luhn pass, length and range extremes
    card_queue.push_back(63'd0);
    card_queue.push_back(63'd1);
    card_queue.push_back(63'd9);
    card_queue.push_back(63'd10);
    card_queue.push_back(63'd18);
    card_queue.push_back(63'h7FFF_FFFF_FFFF_FFFF);
    card_queue.push_back(63'd1000000000000000000);
    card_queue.push_back(63'd999999999999999999);
    // each class on and just off its prefix and length
    card_queue.push_back(make_card(15, 34));
    card_queue.push_back(make_card(15, 37));
    card_queue.push_back(make_card(15, 35));
    card_queue.push_back(make_card(14, 34));
    card_queue.push_back(make_card(16, 51));
    card_queue.push_back(make_card(16, 55));
    card_queue.push_back(make_card(16, 50));
    card_queue.push_back(make_card(16, 56));
    card_queue.push_back(make_card(13, 4));
    card_queue.push_back(make_card(16, 4));
    card_queue.push_back(make_card(15, 4));
    card_queue.push_back(make_card(19, 4));
    // good prefix and length but failing checksum
    card_queue.push_back(break_card(make_card(15, 37)));
    card_queue.push_back(break_card(make_card(16, 53)));
    card_queue.push_back(break_card(make_card(13, 4)));

    // each phase drains fully before the next, so the sender also pauses for the block
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) card_queue.push_back(random_card());
      do @(negedge clk);
      while (card_queue.size() != 0 || in_valid || verdict_queue.size() != 0);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_queue.size() == 0) begin
      $display("PASS luhn_card_number_classifier_core");
    end else begin
      $display("FAIL luhn_card_number_classifier_core");
    end
    $finish;
  end

endmodule
